/* rtl/core/pclm_pkg.sv */
// Shared widths, register map and constants of the pulse count level meter.
package pclm_pkg;

	localparam int COUNT_WIDTH_DEF  = 16;
	localparam int WINDOW_WIDTH_DEF = 20;

	localparam int CAL_W    = 16;   // dry / wet calibration counts
	localparam int WIN_W    = 20;   // window length register
	localparam int TOTAL_W  = 16;   // pulse_total field
	localparam int LEVEL_W  = 8;
	localparam int PCT_W    = 7;
	localparam int DUTY_W   = 8;
	localparam int APB_DW   = 32;
	localparam int APB_AW   = 4;

	localparam logic [WIN_W-1:0] WINDOW_RESET = 20'd100000;

	// register index, paddr[3:2]
	localparam logic [1:0] REG_DRY    = 2'd0;
	localparam logic [1:0] REG_WET    = 2'd1;
	localparam logic [1:0] REG_WINDOW = 2'd2;

	localparam logic [7:0] FULL       = 8'd255;
	localparam logic [7:0] LOW_LEVEL  = 8'd15;
	localparam logic [7:0] RED_SPAN   = 8'd70;
	localparam logic [7:0] YELLOW_TOP = 8'd140;
	localparam logic [7:0] GREEN_SPAN = 8'd115;
	localparam logic [7:0] PCT_SCALE  = 8'd100;

endpackage

/* rtl/core/pclm_ifs.sv */
// Valid/ready channel interfaces: tick input and level result output.
interface pclm_in_if;
	logic valid;
	logic ready;
	logic pulse_end;

	modport source (output valid, output pulse_end, input ready);
	modport sink (input valid, input pulse_end, output ready);
endinterface

interface pclm_out_if;
	logic                         valid;
	logic                         ready;
	logic [pclm_pkg::TOTAL_W-1:0] pulse_total;
	logic [pclm_pkg::LEVEL_W-1:0] level;
	logic [pclm_pkg::PCT_W-1:0]   percent;
	logic [pclm_pkg::DUTY_W-1:0]  red_duty;
	logic [pclm_pkg::DUTY_W-1:0]  yellow_duty;
	logic [pclm_pkg::DUTY_W-1:0]  green_duty;
	logic                         red_blink;
	logic                         config_error;

	modport source (output valid, output pulse_total, output level, output percent,
		output red_duty, output yellow_duty, output green_duty, output red_blink,
		output config_error, input ready);
	modport sink (input valid, input pulse_total, input level, input percent,
		input red_duty, input yellow_duty, input green_duty, input red_blink,
		input config_error, output ready);
endinterface

/* rtl/core/pulse_count_level_meter_top.sv */
// Pulse count level meter: window counter, shared divider and result register.
//
// Usage:
//  - in_ch carries one item per microsecond tick; pulse_end flags a finished
//    oscillator pulse. Pulses are counted (saturating) over window_ticks ticks.
//  - The tick that closes a window yields one item on out_ch: pulse total,
//    level 0..255, percent, red/yellow/green lamp duties, low-level blink
//    request and a calibration error flag (wet > dry).
//  - APB port: 0x0 dry_count, 0x4 wet_count, 0x8 window_ticks. pready is tied
//    high; write only while the block is idle.
// Timing:
//  - Ordinary ticks are taken back to back.
//  - A window-closing tick runs a short sequence through one shared 8-step
//    restoring divider (level, percent, lamp duty); in_ch.ready stays low until
//    the result is handed to the output register.
//  - The result moves into an output register, so counting resumes while it
//    waits; ticks stall again only once the next result is done and still full.
// Reset: counters clear, window_ticks returns to 100000, calibration to 0,
//  no result is pending.
module pulse_count_level_meter_top #(
	parameter int COUNT_WIDTH  = pclm_pkg::COUNT_WIDTH_DEF,
	parameter int WINDOW_WIDTH = pclm_pkg::WINDOW_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	pclm_in_if.sink                     in_ch,
	pclm_out_if.source                  out_ch,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pclm_pkg::APB_AW-1:0] paddr,
	input  logic [pclm_pkg::APB_DW-1:0] pwdata,
	output logic [pclm_pkg::APB_DW-1:0] prdata,
	output logic                        pready
);

	// window compare width: wide enough for both the register and the counter
	localparam int WCMP = (WINDOW_WIDTH > pclm_pkg::WIN_W) ? WINDOW_WIDTH : pclm_pkg::WIN_W;

	localparam logic [1:0] REG_DRY_IDX = pclm_pkg::REG_DRY;
	localparam logic [1:0] REG_WET_IDX = pclm_pkg::REG_WET;
	localparam logic [1:0] REG_WIN_IDX = pclm_pkg::REG_WINDOW;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_LSET = 7'b0000010,
		ST_LDIV = 7'b0000100,
		ST_PSET = 7'b0001000,
		ST_PDIV = 7'b0010000,
		ST_CSET = 7'b0100000,
		ST_CDIV = 7'b1000000
	} state_t;

	typedef enum logic [2:0] {
		LAMP_RED = 3'b001,
		LAMP_YEL = 3'b010,
		LAMP_GRN = 3'b100
	} lamp_t;

	// DONE is folded in as the idle-with-result-pending case below
	logic                        done_q;

	state_t                      state_q;
	lamp_t                       lamp_q;

	// configuration
	logic [pclm_pkg::CAL_W-1:0]  dry_q;
	logic [pclm_pkg::CAL_W-1:0]  wet_q;
	logic [pclm_pkg::WIN_W-1:0]  win_q;

	// window counters
	logic [WINDOW_WIDTH-1:0]     tick_q;
	logic [COUNT_WIDTH-1:0]      pulse_q;
	logic [COUNT_WIDTH-1:0]      total_q;

	// working result
	logic [7:0]                  level_q;
	logic [6:0]                  pct_q;
	logic [7:0]                  red_q;
	logic [7:0]                  yel_q;
	logic [7:0]                  grn_q;
	logic                        blink_q;
	logic                        err_q;

	// output register
	logic                        ovalid_q;
	logic [15:0]                 otot_q;
	logic [7:0]                  olevel_q;
	logic [6:0]                  opct_q;
	logic [7:0]                  ored_q;
	logic [7:0]                  oyel_q;
	logic [7:0]                  ogrn_q;
	logic                        oblink_q;
	logic                        oerr_q;

	// shared divider: 24-bit dividend, 16-bit divisor, 8-bit quotient
	logic [15:0]                 rem_q;
	logic [7:0]                  low_q;
	logic [15:0]                 dvs_q;
	logic [7:0]                  quo_q;
	logic [2:0]                  dcnt_q;

	logic                        cfg_wr;
	logic                        in_acc;
	logic                        out_free;
	logic [COUNT_WIDTH-1:0]      cnt_inc;
	logic [WCMP-1:0]             win_ext;
	logic [WCMP-1:0]             win_max;
	logic [WCMP-1:0]             win_eff;
	logic [WCMP-1:0]             tick_inc;
	logic                        win_end;
	logic [31:0]                 total_ext;
	logic [15:0]                 num;
	logic [15:0]                 den;
	logic                        cal_err;
	logic                        lvl_by_div;
	logic                        lvl_low;
	lamp_t                       lamp_sel;
	logic [7:0]                  lvl_off;
	logic [7:0]                  lamp_span;
	logic                        div_ld;
	logic                        div_step;
	logic                        div_done;
	logic [23:0]                 div_n;
	logic [15:0]                 div_d;
	logic [16:0]                 dtrial;
	logic [16:0]                 ddiff;
	logic                        dge;
	logic [15:0]                 rem_next;
	logic [7:0]                  quo_next;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_comb begin
		unique case (paddr[3:2])
			REG_DRY_IDX: prdata = 32'(dry_q);
			REG_WET_IDX: prdata = 32'(wet_q);
			REG_WIN_IDX: prdata = 32'(win_q);
			default:     prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dry_q <= '0;
			wet_q <= '0;
			win_q <= pclm_pkg::WINDOW_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_DRY_IDX: dry_q <= pwdata[pclm_pkg::CAL_W-1:0];
				REG_WET_IDX: wet_q <= pwdata[pclm_pkg::CAL_W-1:0];
				REG_WIN_IDX: win_q <= pwdata[pclm_pkg::WIN_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- window counting ----------------
	assign in_ch.ready = (state_q == ST_IDLE) && !done_q;
	assign in_acc      = in_ch.valid & in_ch.ready;

	assign cnt_inc = (in_ch.pulse_end && (pulse_q != {COUNT_WIDTH{1'b1}}))
		? pulse_q + COUNT_WIDTH'(1) : pulse_q;

	// zero window acts as one; a window beyond the counter clamps to its max
	assign win_ext  = WCMP'(win_q);
	assign win_max  = WCMP'({WINDOW_WIDTH{1'b1}});
	assign win_eff  = (win_ext == '0) ? WCMP'(1) : ((win_ext > win_max) ? win_max : win_ext);
	assign tick_inc = WCMP'(tick_q) + WCMP'(1);
	assign win_end  = (tick_inc >= win_eff);

	// ---------------- level operands ----------------
	assign total_ext  = 32'(total_q);
	assign cal_err    = (wet_q > dry_q);
	assign num        = (32'(dry_q) > total_ext) ? (dry_q - total_ext[15:0]) : '0;
	assign den        = dry_q - wet_q;
	// num < den keeps the quotient below 255; otherwise level saturates
	assign lvl_by_div = (num < den);

	always_comb begin
		lvl_low   = 1'b0;
		lamp_sel  = LAMP_RED;
		lvl_off   = level_q;
		lamp_span = pclm_pkg::RED_SPAN;
		if (level_q <= pclm_pkg::LOW_LEVEL) begin
			lvl_low = 1'b1;
		end else if (level_q <= pclm_pkg::RED_SPAN) begin
			lamp_sel = LAMP_RED;
		end else if (level_q <= pclm_pkg::YELLOW_TOP) begin
			lamp_sel = LAMP_YEL;
			lvl_off  = level_q - pclm_pkg::RED_SPAN;
		end else begin
			lamp_sel  = LAMP_GRN;
			lvl_off   = level_q - pclm_pkg::YELLOW_TOP;
			lamp_span = pclm_pkg::GREEN_SPAN;
		end
	end

	// ---------------- shared divider ----------------
	always_comb begin
		div_ld = 1'b0;
		div_n  = '0;
		div_d  = '0;
		unique case (state_q)
			ST_LSET: begin
				div_ld = !cal_err && lvl_by_div;
				div_n  = {num, 8'd0} - 24'(num);
				div_d  = den;
			end
			ST_PSET: begin
				div_ld = 1'b1;
				div_n  = 24'(level_q) * 24'(pclm_pkg::PCT_SCALE);
				div_d  = 16'(pclm_pkg::FULL);
			end
			ST_CSET: begin
				div_ld = !lvl_low;
				div_n  = {8'd0, lvl_off, 8'd0} - 24'(lvl_off);
				div_d  = 16'(lamp_span);
			end
			default: ;
		endcase
	end

	assign div_step = (state_q == ST_LDIV) || (state_q == ST_PDIV) || (state_q == ST_CDIV);
	assign div_done = div_step && (dcnt_q == 3'd7);
	assign dtrial   = {rem_q, low_q[7]};
	assign ddiff    = dtrial - {1'b0, dvs_q};
	assign dge      = (dtrial >= {1'b0, dvs_q});
	assign rem_next = dge ? ddiff[15:0] : dtrial[15:0];
	assign quo_next = {quo_q[6:0], dge};

	// ---------------- sequencer ----------------
	assign out_free = !ovalid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			done_q   <= 1'b0;
			ovalid_q <= 1'b0;
			tick_q   <= '0;
			pulse_q  <= '0;
			dcnt_q   <= '0;
			lamp_q   <= LAMP_RED;
		end else begin
			if (div_ld) begin
				dcnt_q <= '0;
			end else if (div_step) begin
				dcnt_q <= dcnt_q + 3'd1;
			end

			if (done_q && out_free) begin
				ovalid_q <= 1'b1;
				done_q   <= 1'b0;
			end else if (out_ch.ready) begin
				ovalid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (win_end) begin
							tick_q  <= '0;
							pulse_q <= '0;
							state_q <= ST_LSET;
						end else begin
							tick_q  <= tick_inc[WINDOW_WIDTH-1:0];
							pulse_q <= cnt_inc;
						end
					end
				end
				ST_LSET: begin
					if (cal_err) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (lvl_by_div) begin
						state_q <= ST_LDIV;
					end else begin
						state_q <= ST_PSET;
					end
				end
				ST_LDIV: if (div_done) state_q <= ST_PSET;
				ST_PSET: state_q <= ST_PDIV;
				ST_PDIV: if (div_done) state_q <= ST_CSET;
				ST_CSET: begin
					lamp_q <= lamp_sel;
					if (lvl_low) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_CDIV;
					end
				end
				ST_CDIV: begin
					if (div_done) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------- datapath ----------------
	always_ff @(posedge clk) begin
		if (div_ld) begin
			rem_q <= div_n[23:8];
			low_q <= div_n[7:0];
			dvs_q <= div_d;
			quo_q <= '0;
		end else if (div_step) begin
			rem_q <= rem_next;
			low_q <= {low_q[6:0], 1'b0};
			quo_q <= quo_next;
		end

		if (done_q && out_free) begin
			otot_q   <= total_ext[15:0];
			olevel_q <= level_q;
			opct_q   <= pct_q;
			ored_q   <= red_q;
			oyel_q   <= yel_q;
			ogrn_q   <= grn_q;
			oblink_q <= blink_q;
			oerr_q   <= err_q;
		end

		unique case (state_q)
			ST_IDLE: if (in_acc && win_end) total_q <= cnt_inc;
			ST_LSET: begin
				err_q   <= cal_err;
				blink_q <= 1'b0;
				pct_q   <= '0;
				red_q   <= '0;
				yel_q   <= '0;
				grn_q   <= '0;
				if (cal_err) begin
					level_q <= '0;
				end else if (!lvl_by_div) begin
					level_q <= (num != '0) ? pclm_pkg::FULL : 8'd0;
				end
			end
			ST_LDIV: if (div_done) level_q <= quo_next;
			ST_PDIV: if (div_done) pct_q <= quo_next[6:0];
			ST_CSET: begin
				if (lvl_low) begin
					blink_q <= 1'b1;
				end else begin
					red_q <= (lamp_sel != LAMP_RED) ? pclm_pkg::FULL : 8'd0;
					yel_q <= (lamp_sel == LAMP_GRN) ? pclm_pkg::FULL : 8'd0;
				end
			end
			ST_CDIV: begin
				if (div_done) begin
					unique case (lamp_q)
						LAMP_RED: red_q <= quo_next;
						LAMP_YEL: yel_q <= quo_next;
						LAMP_GRN: grn_q <= quo_next;
						default: ;
					endcase
				end
			end
			default: ;
		endcase
	end

	// ---------------- output channel ----------------
	assign out_ch.valid        = ovalid_q;
	assign out_ch.pulse_total  = otot_q;
	assign out_ch.level        = olevel_q;
	assign out_ch.percent      = opct_q;
	assign out_ch.red_duty     = ored_q;
	assign out_ch.yellow_duty  = oyel_q;
	assign out_ch.green_duty   = ogrn_q;
	assign out_ch.red_blink    = oblink_q;
	assign out_ch.config_error = oerr_q;

endmodule

/* rtl/core/pclm_checker.sv */
// Port-level checker for the level meter, bound to the top level.
module pclm_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [pclm_pkg::TOTAL_W-1:0] pulse_total,
	input logic [pclm_pkg::LEVEL_W-1:0] level,
	input logic [pclm_pkg::PCT_W-1:0]   percent,
	input logic [pclm_pkg::DUTY_W-1:0]  red_duty,
	input logic [pclm_pkg::DUTY_W-1:0]  yellow_duty,
	input logic [pclm_pkg::DUTY_W-1:0]  green_duty,
	input logic                         red_blink,
	input logic                         config_error
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(pulse_total) && $stable(level)
			&& $stable(config_error))
		else $error("result changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && config_error |-> level == '0 && percent == '0 && red_duty == '0
			&& yellow_duty == '0 && green_duty == '0 && !red_blink)
		else $error("calibration error with nonzero outputs");

	a_blink: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !config_error |-> (red_blink == (level <= pclm_pkg::LOW_LEVEL))
			&& (!red_blink || red_duty == '0) && (percent <= 7'(pclm_pkg::PCT_SCALE)))
		else $error("blink, red duty or percent inconsistent with level");

	a_lamp_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && green_duty != '0 |-> red_duty == pclm_pkg::FULL
			&& yellow_duty == pclm_pkg::FULL)
		else $error("green lit without full red and yellow");

endmodule

bind pulse_count_level_meter_top pclm_checker u_pclm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.pulse_total  (out_ch.pulse_total),
	.level        (out_ch.level),
	.percent      (out_ch.percent),
	.red_duty     (out_ch.red_duty),
	.yellow_duty  (out_ch.yellow_duty),
	.green_duty   (out_ch.green_duty),
	.red_blink    (out_ch.red_blink),
	.config_error (out_ch.config_error)
);

/* verif/pulse_count_level_meter_top_tb.sv */
// Self-checking testbench for the pulse count level meter top level.
`timescale 1ns / 1ps

module pulse_count_level_meter_top_tb;
	import pclm_pkg::*;

	localparam int CYCLE_LIMIT   = 1_000_000;
	// Margin for the longest window-end sequence to finish.
	localparam int SETTLE_CYCLES = 40;
	localparam int MAX_REPORTS   = 10;
	// Register slot past the end of the map; writes there must change nothing.
	localparam logic [1:0] REG_UNMAPPED = 2'd3;

	// One window-end reading, field for field as it leaves out_ch.
	typedef struct packed {
		logic [TOTAL_W-1:0] pulse_total;
		logic [LEVEL_W-1:0] level;
		logic [PCT_W-1:0]   percent;
		logic [DUTY_W-1:0]  red_duty;
		logic [DUTY_W-1:0]  yellow_duty;
		logic [DUTY_W-1:0]  green_duty;
		logic               red_blink;
		logic               config_error;
	} meter_reading_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;

	pclm_in_if  tick_if ();
	pclm_out_if reading_if ();

	pulse_count_level_meter_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (tick_if),
		.out_ch  (reading_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	// Mirror of the block: calibration, window length and the two counters.
	logic [CAL_W-1:0]            cal_dry;
	logic [CAL_W-1:0]            cal_wet;
	logic [WIN_W-1:0]            win_len;
	int unsigned                 ticks_seen;
	logic [COUNT_WIDTH_DEF-1:0]  pulses_seen;

	meter_reading_t pending_readings[$];
	meter_reading_t head_reading;
	int mismatch_count = 0;
	int src_idle_pct   = 0;
	int snk_stall_pct  = 0;
	int cycle_count    = 0;

	// Level, percent and lamp duties for one finished window, all exact floors.
	function automatic meter_reading_t grade_level(input logic [COUNT_WIDTH_DEF-1:0] total);
		meter_reading_t r;
		int unsigned num;
		int unsigned den;
		int unsigned lvl;
		r = '0;
		r.pulse_total = total[TOTAL_W-1:0];
		if (cal_wet > cal_dry) begin
			// bad calibration: everything but the total and the flag stays zero
			r.config_error = 1'b1;
		end else begin
			num = (cal_dry > total) ? 32'(cal_dry) - 32'(total) : 0;
			den = 32'(cal_dry) - 32'(cal_wet);
			if (den == 0) begin
				// equal calibration: all or nothing
				lvl = (num > 0) ? FULL : 0;
			end else begin
				lvl = num * FULL / den;
				if (lvl > FULL)
					lvl = FULL;
			end
			r.level   = 8'(lvl);
			r.percent = 7'(lvl * PCT_SCALE / FULL);
			if (lvl <= LOW_LEVEL) begin
				// red lamp left to the blink request
				r.red_blink = 1'b1;
			end else if (lvl <= RED_SPAN) begin
				r.red_duty = 8'(lvl * FULL / RED_SPAN);
			end else if (lvl <= YELLOW_TOP) begin
				r.red_duty    = FULL;
				r.yellow_duty = 8'((lvl - RED_SPAN) * FULL / RED_SPAN);
			end else begin
				r.red_duty    = FULL;
				r.yellow_duty = FULL;
				r.green_duty  = 8'((lvl - YELLOW_TOP) * FULL / GREEN_SPAN);
			end
		end
		return r;
	endfunction

	// One accepted tick: count, and close the window when it is full.
	// A window shrunk below the ticks already seen closes on the next tick.
	function automatic void advance_window(input bit pe);
		int unsigned win;
		win = (win_len == '0) ? 1 : 32'(win_len);
		if (pe && pulses_seen != '1)
			pulses_seen++;
		ticks_seen++;
		if (ticks_seen >= win) begin
			pending_readings.push_back(grade_level(pulses_seen));
			ticks_seen  = 0;
			pulses_seen = '0;
		end
	endfunction

	function automatic void check_field(input string name, input longint unsigned want,
		input longint unsigned got);
		if (want != got) begin
			mismatch_count++;
			if (mismatch_count <= MAX_REPORTS)
				$display("mismatch %s: expected %0d, got %0d", name, want, got);
		end
	endfunction

	// Receiver side: random stalls at the rate of the current phase.
	always @(posedge clk) begin
		reading_if.ready <= ($urandom_range(99) >= snk_stall_pct);
	end

	// Every accepted reading is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && reading_if.valid && reading_if.ready) begin
			if (pending_readings.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected reading: total %0d level %0d",
						reading_if.pulse_total, reading_if.level);
			end else begin
				head_reading = pending_readings.pop_front();
				check_field("pulse_total", head_reading.pulse_total, reading_if.pulse_total);
				check_field("level", head_reading.level, reading_if.level);
				check_field("percent", head_reading.percent, reading_if.percent);
				check_field("red_duty", head_reading.red_duty, reading_if.red_duty);
				check_field("yellow_duty", head_reading.yellow_duty, reading_if.yellow_duty);
				check_field("green_duty", head_reading.green_duty, reading_if.green_duty);
				check_field("red_blink", head_reading.red_blink, reading_if.red_blink);
				check_field("config_error", head_reading.config_error,
					reading_if.config_error);
			end
		end
	end

	// Watchdog: a hung handshake ends the run here.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL pulse_count_level_meter_top");
		$finish;
	end

	// Offer one tick, with random idle cycles ahead of it; returns on the accept edge.
	task automatic send_tick(input bit pe);
		while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			tick_if.valid <= 1'b0;
			@(posedge clk);
		end
		tick_if.valid     <= 1'b1;
		tick_if.pulse_end <= pe;
		do @(posedge clk); while (!tick_if.ready);
		advance_window(pe);
	endtask

	// Drop valid, wait out every pending reading, then the divider's worst case.
	task automatic settle();
		tick_if.valid <= 1'b0;
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Setup and access phase, then psel drops before returning so transfers never overlap.
	task automatic apb_xfer(input logic wr, input logic [1:0] idx,
		input logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic verify_reg(input logic [1:0] idx);
		logic [APB_DW-1:0] rd;
		apb_xfer(1'b0, idx, '0, rd);
		case (idx)
			REG_DRY:    check_field("dry_count readback", cal_dry, rd);
			REG_WET:    check_field("wet_count readback", cal_wet, rd);
			REG_WINDOW: check_field("window_ticks readback", win_len, rd);
			default: ;
		endcase
	endtask

	// Only called with the block idle; mirror follows, mapped registers read back.
	task automatic write_reg(input logic [1:0] idx, input logic [APB_DW-1:0] value);
		logic [APB_DW-1:0] rd;
		apb_xfer(1'b1, idx, value, rd);
		case (idx)
			REG_DRY:    cal_dry = value[CAL_W-1:0];
			REG_WET:    cal_wet = value[CAL_W-1:0];
			REG_WINDOW: win_len = value[WIN_W-1:0];
			default: ;
		endcase
		if (idx != REG_UNMAPPED)
			verify_reg(idx);
	endtask

	// Reset values, then a window cut short below the ticks already counted.
	task automatic test_reset_state();
		verify_reg(REG_DRY);
		verify_reg(REG_WET);
		verify_reg(REG_WINDOW);
		send_tick(1'b1);
		send_tick(1'b1);
		send_tick(1'b0);
		settle();
		write_reg(REG_WINDOW, 2);
		send_tick(1'b1);
		settle();
	endtask

	// Window length 0 behaves as 1: each tick is its own window.
	// Equal calibration gives 255 with room left, 0 without.
	task automatic test_zero_window();
		write_reg(REG_DRY, 1);
		write_reg(REG_WET, 1);
		write_reg(REG_WINDOW, 0);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b0);
		settle();
	endtask

	// A pulse flagged on the closing tick still belongs to that window.
	task automatic test_last_tick_pulse();
		write_reg(REG_DRY, 2);
		write_reg(REG_WET, 0);
		write_reg(REG_WINDOW, 3);
		send_tick(1'b0);
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b0);
		settle();
	endtask

	// Calibration error both ways, empty and full level, top of the dry range.
	task automatic test_calibration();
		write_reg(REG_WINDOW, 2);
		write_reg(REG_DRY, 3);
		write_reg(REG_WET, 10);
		send_tick(1'b1);
		send_tick(1'b1);
		settle();
		write_reg(REG_DRY, 0);
		write_reg(REG_WET, 32'h0000_FFFF);
		send_tick(1'b0);
		send_tick(1'b0);
		settle();
		// count reaches dry: level 0, red duty off, blink on
		write_reg(REG_DRY, 2);
		write_reg(REG_WET, 0);
		send_tick(1'b1);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b0);
		settle();
		write_reg(REG_DRY, 32'h0000_FFFF);
		send_tick(1'b1);
		send_tick(1'b0);
		settle();
	endtask

	// A long window, a write to the unmapped slot, then a one-tick window.
	task automatic test_register_extremes();
		int k;
		write_reg(REG_WINDOW, 1_000_000);
		for (k = 0; k < 5; k++)
			send_tick(1'b1);
		settle();
		write_reg(REG_DRY, 32'h0000_FFFF);
		write_reg(REG_WET, 32'h0000_FFFF);
		write_reg(REG_WINDOW, 1);
		send_tick(1'b1);
		settle();
		write_reg(REG_UNMAPPED, $urandom());
		verify_reg(REG_DRY);
		verify_reg(REG_WET);
		verify_reg(REG_WINDOW);
		send_tick(1'b1);
		settle();
	endtask

	// Segments of random ticks, each under a fresh random setting.
	task automatic test_random_traffic(input int src_pct, input int snk_pct, input int n_ticks);
		int sent;
		int seg_len;
		int density;
		int pick;
		int j;
		logic [CAL_W-1:0] d;
		logic [CAL_W-1:0] w;
		logic [WIN_W-1:0] win;
		src_idle_pct  = src_pct;
		snk_stall_pct = snk_pct;
		sent = 0;
		while (sent < n_ticks) begin
			pick = $urandom_range(99);
			if (pick < 5)
				win = '0;
			else if (pick < 75)
				win = WIN_W'($urandom_range(12, 1));
			else if (pick < 95)
				win = WIN_W'($urandom_range(40, 13));
			else
				win = WIN_W'($urandom_range(120, 41));
			// keep dry near the reachable totals so levels spread out
			d = CAL_W'($urandom_range(int'(win) + 10, 0));
			pick = $urandom_range(99);
			if (pick < 65) begin
				w = CAL_W'($urandom_range(int'(d), 0));
			end else if (pick < 75) begin
				w = d;
			end else if (pick < 88) begin
				w = CAL_W'($urandom_range(int'(d) + 30, int'(d) + 1));
			end else begin
				d = CAL_W'($urandom());
				w = CAL_W'($urandom());
			end
			write_reg(REG_WINDOW, APB_DW'(win));
			write_reg(REG_DRY, APB_DW'(d));
			write_reg(REG_WET, APB_DW'(w));
			density = $urandom_range(100, 0);
			seg_len = $urandom_range(50, 10);
			for (j = 0; j < seg_len; j++)
				send_tick($urandom_range(99) < density);
			sent += seg_len;
			settle();
		end
	endtask

	initial begin
		arst_n            <= 1'b0;
		tick_if.valid     <= 1'b0;
		tick_if.pulse_end <= 1'b0;
		psel              <= 1'b0;
		penable           <= 1'b0;
		pwrite            <= 1'b0;
		paddr             <= '0;
		pwdata            <= '0;
		cal_dry     = '0;
		cal_wet     = '0;
		win_len     = WINDOW_RESET;
		ticks_seen  = 0;
		pulses_seen = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		settle();

		test_reset_state();
		test_zero_window();
		test_last_tick_pulse();
		test_calibration();
		test_register_extremes();
		// no idling, sender idle, receiver stalling, both
		test_random_traffic(0, 0, 230);
		test_random_traffic(80, 0, 230);
		test_random_traffic(0, 80, 230);
		test_random_traffic(19, 19, 230);

		if (mismatch_count == 0 && pending_readings.size() == 0)
			$display("PASS pulse_count_level_meter_top");
		else
			$display("FAIL pulse_count_level_meter_top");
		$finish;
	end

endmodule
